@@ rtl/path_proximity_point_filter_assert.svh @@
// Assertion macros used by the path proximity filter checker.
`ifndef PATH_PROXIMITY_POINT_FILTER_ASSERT_SVH
`define PATH_PROXIMITY_POINT_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PPPF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PPPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pppf_pkg.sv @@
// Constants and codes of the path proximity point filter.
package pppf_pkg;

	localparam int PATH_DEPTH  = 256;
	// At most FIELD_W: coordinates come from the low bits of the 24-bit fields.
	localparam int COORD_WIDTH = 24;

	localparam int FIELD_W = 24;
	localparam int MODE_W  = 2;
	localparam int RAD_W   = 50;
	localparam int DATA_W  = 64;
	localparam int ADDR_W  = 4;

	localparam int IDX_W = $clog2(PATH_DEPTH);
	localparam int CNT_W = $clog2(PATH_DEPTH + 1);
	// |a - b| of two COORD_WIDTH signed values fits COORD_WIDTH unsigned bits.
	localparam int MAG_W = COORD_WIDTH;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 1;
	localparam int CMP_W = (SUM_W > RAD_W) ? SUM_W : RAD_W;

	localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(589824);

	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TEST   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

endpackage

@@ rtl/path_proximity_point_filter.sv @@
// Top level of the path proximity point filter: path table, distance sequencer, APB register.
// Clear, append and unused-mode commands complete at the accepting edge; busy stays low.
// A test of a filled table walks its points one at a time on one shared squarer, busy high,
// until the first hit or the last point; a kept point strobes kept_valid as busy drops.
// arst_n clears point count, sequencer and strobe, loads radius_squared with 768^2;
// table contents stay undefined until appended.
module path_proximity_point_filter
	import pppf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     start,
	output logic                     busy,
	input  logic [MODE_W-1:0]        mode,
	input  logic signed [FIELD_W-1:0] x_pos,
	input  logic signed [FIELD_W-1:0] y_pos,
	input  logic signed [FIELD_W-1:0] z_pos,

	output logic                     kept_valid,
	output logic signed [FIELD_W-1:0] kept_x,
	output logic signed [FIELD_W-1:0] kept_y,
	output logic signed [FIELD_W-1:0] kept_z,

	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	// Sequencer states. One path point per DIFF -> SQX -> SQY -> CMP round.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIFF = 3'd1; // table entry arrived, form |dx|, |dy|
	localparam logic [2:0] ST_SQX  = 3'd2; // squarer on |dx|
	localparam logic [2:0] ST_SQY  = 3'd3; // squarer on |dy|
	localparam logic [2:0] ST_CMP  = 3'd4; // add and compare with radius

	// Register index: 8-byte registers, so the index is the address bit above the offset.
	localparam logic REG_RADIUS = 1'b0;

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;    // valid entries in the table
	logic [CNT_W-1:0]       idx_q;    // next entry to read
	logic [RAD_W-1:0]       rad_q;

	// Path table; read port registered, address idx_q every cycle.
	logic signed [COORD_WIDTH-1:0] mem_x [PATH_DEPTH];
	logic signed [COORD_WIDTH-1:0] mem_y [PATH_DEPTH];
	logic signed [COORD_WIDTH-1:0] rdx_q, rdy_q;

	// Captured test point, raw fields.
	logic signed [FIELD_W-1:0] px_q, py_q, pz_q;

	logic [MAG_W-1:0]       dx_q, dy_q;
	logic [SQ_W-1:0]        sqx_q, sqy_q;

	logic                   accept;
	logic                   cfg_wr;
	logic                   full;
	logic signed [COORD_WIDTH-1:0] in_x, in_y, pt_x, pt_y;
	logic signed [COORD_WIDTH:0]   diff_x, diff_y;
	logic [MAG_W-1:0]       mul_in;
	logic [SQ_W-1:0]        mul_out;
	logic [CMP_W-1:0]       dist_sq;
	logic                   hit;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full   = (cnt_q == CNT_W'(PATH_DEPTH));

	assign in_x = x_pos[COORD_WIDTH-1:0];
	assign in_y = y_pos[COORD_WIDTH-1:0];
	assign pt_x = px_q[COORD_WIDTH-1:0];
	assign pt_y = py_q[COORD_WIDTH-1:0];

	// Differences at one extra bit; magnitude fits MAG_W bits.
	assign diff_x = {pt_x[COORD_WIDTH-1], pt_x} - {rdx_q[COORD_WIDTH-1], rdx_q};
	assign diff_y = {pt_y[COORD_WIDTH-1], pt_y} - {rdy_q[COORD_WIDTH-1], rdy_q};

	// The one shared squarer.
	assign mul_in  = (state_q == ST_SQX) ? dx_q : dy_q;
	assign mul_out = SQ_W'(mul_in) * SQ_W'(mul_in);

	assign dist_sq = CMP_W'(sqx_q) + CMP_W'(sqy_q);
	assign hit     = dist_sq < CMP_W'(rad_q);

	// Table storage: appends write at cnt_q, the read port follows idx_q.
	always_ff @(posedge clk) begin
		if (accept && mode == MODE_APPEND && !full) begin
			mem_x[cnt_q[IDX_W-1:0]] <= in_x;
			mem_y[cnt_q[IDX_W-1:0]] <= in_y;
		end
		rdx_q <= mem_x[idx_q[IDX_W-1:0]];
		rdy_q <= mem_y[idx_q[IDX_W-1:0]];
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		if (accept && mode == MODE_TEST) begin
			px_q <= x_pos;
			py_q <= y_pos;
			pz_q <= z_pos;
		end
		if (state_q == ST_DIFF) begin
			dx_q <= diff_x[COORD_WIDTH] ? MAG_W'(-diff_x) : MAG_W'(diff_x);
			dy_q <= diff_y[COORD_WIDTH] ? MAG_W'(-diff_y) : MAG_W'(diff_y);
		end
		if (state_q == ST_SQX) begin
			sqx_q <= mul_out;
		end
		if (state_q == ST_SQY) begin
			sqy_q <= mul_out;
		end
		if (state_q == ST_CMP && hit) begin
			kept_x <= px_q;
			kept_y <= py_q;
			kept_z <= pz_q;
		end
	end

	// Command handling and the walk sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			kept_valid <= 1'b0;
		end else begin
			kept_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_CLEAR: begin
								cnt_q <= '0;
							end
							MODE_APPEND: begin
								if (!full) begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							MODE_TEST: begin
								// Entry 0 is already on the read port.
								if (cnt_q != '0) begin
									state_q <= ST_DIFF;
								end
							end
							MODE_NONE: begin
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIFF: begin
					idx_q   <= idx_q + 1'b1; // prefetch next entry during the round
					state_q <= ST_SQX;
				end
				ST_SQX: begin
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (hit) begin
						kept_valid <= 1'b1;
						idx_q      <= '0;
						state_q    <= ST_IDLE;
					end else if (idx_q == cnt_q) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIFF;
					end
				end
				default: begin
					idx_q   <= '0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// APB register port; zero wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q <= RAD_RESET;
		end else if (cfg_wr && paddr[ADDR_W-1] == REG_RADIUS) begin
			rad_q <= pwdata[RAD_W-1:0];
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1])
			REG_RADIUS: prdata = DATA_W'(rad_q);
			default:    prdata = '0;
		endcase
	end

endmodule

@@ rtl/pppf_checker.sv @@
// Port-level checker of the path proximity point filter, with its bind.
module pppf_checker
	import pppf_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [MODE_W-1:0] mode,
	input logic              kept_valid,
	input logic              psel,
	input logic              penable,
	input logic              pready
);

	logic table_cmd;

	assign table_cmd = start && !busy &&
		(mode == MODE_CLEAR || mode == MODE_APPEND || mode == MODE_NONE);

`include "path_proximity_point_filter_assert.svh"

	// A kept point is only shown once the walk has ended.
	`PPPF_ASSERT_SAME(a_kept_idle, kept_valid, !busy, "kept point while walk still busy")

	// The strobe always drops again after it rises: the next hit needs a full round.
	`PPPF_ASSERT_NEXT(a_kept_pulse, kept_valid, !kept_valid, "kept_valid held two cycles")

	// Table commands finish at the accepting edge.
	`PPPF_ASSERT_NEXT(a_table_cmd, table_cmd, !busy && !kept_valid, "table command stalled")

	// A test transfer cannot give its result in the next cycle.
	`PPPF_ASSERT_NEXT(a_test_lat, start && !busy && mode == MODE_TEST, !kept_valid, "early result")

	// Zero-wait register port.
	`PPPF_ASSERT_SAME(a_pready, psel && penable, pready, "register access stalled")

endmodule

bind path_proximity_point_filter pppf_checker u_pppf_checker (.*);

@@ verif/tb_path_proximity_point_filter.sv @@
// Self-checking testbench of the path proximity point filter: command driver, result monitor.
module tb_path_proximity_point_filter;
	import pppf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// A test command walks at most PATH_DEPTH entries, one DIFF-SQX-SQY-CMP round each, and
	// strobes only on a hit. Waiting DRAIN_CYCLES after the last transfer leaves the block idle.
	localparam int DRAIN_CYCLES = 4 * PATH_DEPTH + 16;

	// radius_squared is the only register; it is 50 bits wide, so registers sit 8 bytes
	// apart and index 1 (byte 8) is an unmapped slot that must be ignored.
	localparam logic [ADDR_W-1:0] RADIUS_ADDR   = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(8);

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [FIELD_W-1:0] x;
		logic [FIELD_W-1:0] y;
		logic [FIELD_W-1:0] z;
	} cmd_t;

	typedef struct packed {
		logic [FIELD_W-1:0] x;
		logic [FIELD_W-1:0] y;
		logic [FIELD_W-1:0] z;
	} kept_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      start = 1'b0;
	logic                      busy;
	logic [MODE_W-1:0]         mode = MODE_CLEAR;
	logic signed [FIELD_W-1:0] x_pos = '0;
	logic signed [FIELD_W-1:0] y_pos = '0;
	logic signed [FIELD_W-1:0] z_pos = '0;

	logic                      kept_valid;
	logic signed [FIELD_W-1:0] kept_x;
	logic signed [FIELD_W-1:0] kept_y;
	logic signed [FIELD_W-1:0] kept_z;

	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Commands waiting for the driver, and kept points the monitor still owes.
	cmd_t  cmd_backlog[$];
	kept_t kept_due[$];
	int    idle_pct = 0;
	int    err_count = 0;

	// Generator-side copy of the appended path points, used to aim test points and bound path size.
	logic [FIELD_W-1:0] shadow_x[$];
	logic [FIELD_W-1:0] shadow_y[$];

	// Predictor state: path table, fill count and the keep radius.
	logic signed [COORD_WIDTH-1:0] path_tbl_x[PATH_DEPTH];
	logic signed [COORD_WIDTH-1:0] path_tbl_y[PATH_DEPTH];
	int                            path_cnt = 0;
	logic [RAD_W-1:0]              radius_model = RAD_RESET;

	path_proximity_point_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.z_pos     (z_pos),
		.kept_valid(kept_valid),
		.kept_x    (kept_x),
		.kept_y    (kept_y),
		.kept_z    (kept_z),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: strict less-than of the exact 2D squared distance against
	// the radius, over the filled part of the table. Which entry hits first
	// does not change the result, so any hit keeps the point.
	// ------------------------------------------------------------------
	function automatic bit near_path(input logic signed [COORD_WIDTH-1:0] qx,
					 input logic signed [COORD_WIDTH-1:0] qy);
		longint          dx;
		longint          dy;
		longint unsigned dsq;
		for (int k = 0; k < path_cnt; k++) begin
			dx = longint'(qx) - longint'(path_tbl_x[k]);
			dy = longint'(qy) - longint'(path_tbl_y[k]);
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			// |d| < 2^24, so the sum stays below 2^49: no saturation at this width
			dsq = dx * dx + dy * dy;
			if (dsq < {{(64-RAD_W){1'b0}}, radius_model})
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
				   input logic [FIELD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s differs, expected %0d (0x%06h), got %0d (0x%06h)",
				 $time, name, $signed(want), want, $signed(got), got);
			err_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor and scoreboard. One block, so the order of check, register
	// update and prediction within an edge is fixed: a strobe is always
	// matched against expectations from earlier transfers.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		kept_t want;
		kept_t due_pt;
		if (arst_n) begin
			if (kept_valid) begin
				if (kept_due.size() == 0) begin
					$display("%0t: unexpected kept point, expected none, got (%0d,%0d,%0d)",
						 $time, kept_x, kept_y, kept_z);
					err_count++;
				end else begin
					want = kept_due.pop_front();
					check_field("kept_x", want.x, kept_x);
					check_field("kept_y", want.y, kept_y);
					check_field("kept_z", want.z, kept_z);
				end
			end

			// Register write lands at the access edge; other addresses are ignored.
			if (psel && penable && pwrite && pready && paddr == RADIUS_ADDR)
				radius_model = pwdata[RAD_W-1:0];

			// Command transfer
			if (start && !busy) begin
				case (mode)
					MODE_CLEAR: path_cnt = 0;
					MODE_APPEND: begin
						// appends into a full table are dropped
						if (path_cnt < PATH_DEPTH) begin
							path_tbl_x[path_cnt] = x_pos[COORD_WIDTH-1:0];
							path_tbl_y[path_cnt] = y_pos[COORD_WIDTH-1:0];
							path_cnt++;
						end
					end
					MODE_TEST: begin
						if (near_path(x_pos[COORD_WIDTH-1:0], y_pos[COORD_WIDTH-1:0])) begin
							due_pt = '{x: x_pos, y: y_pos, z: z_pos};
							kept_due = {kept_due, due_pt};
						end
					end
					default: ; // unused mode: no state change, no result
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver. A presented command stays on the port until busy is low at
	// an edge; only then may the next one (or an idle gap) follow.
	// ------------------------------------------------------------------
	cmd_t next_cmd;

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
				next_cmd = cmd_backlog.pop_front();
				start <= 1'b1;
				mode  <= next_cmd.mode;
				x_pos <= next_cmd.x;
				y_pos <= next_cmd.y;
				z_pos <= next_cmd.z;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_cmd(input logic [MODE_W-1:0] m, input logic [FIELD_W-1:0] x,
			       input logic [FIELD_W-1:0] y, input logic [FIELD_W-1:0] z);
		cmd_t c;
		c = '{mode: m, x: x, y: y, z: z};
		cmd_backlog = {cmd_backlog, c};
		if (m == MODE_CLEAR) begin
			shadow_x.delete();
			shadow_y.delete();
		end else if (m == MODE_APPEND && shadow_x.size() < PATH_DEPTH) begin
			shadow_x = {shadow_x, x};
			shadow_y = {shadow_y, y};
		end
	endtask

	// Test point within +/-reach of stored point idx (coordinates wrap at 24 bits).
	task automatic test_near(input int idx, input int reach);
		add_cmd(MODE_TEST,
			shadow_x[idx] + FIELD_W'($urandom_range(2 * reach, 0) - reach),
			shadow_y[idx] + FIELD_W'($urandom_range(2 * reach, 0) - reach),
			FIELD_W'($urandom));
	endtask

	// Everything handed over, then long enough for the last walk to finish.
	task automatic settle();
		do @(negedge clk); while (cmd_backlog.size() != 0 || start);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, access cycle, done at the edge where pready is seen high.
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly well-formed traffic: appends build a small path, test points are
	// aimed near stored points. Clears, unused-mode noise and far-off points mixed in.
	task automatic random_traffic(input int n_items, input int reach);
		int made;
		int sel;
		made = 0;
		while (made < n_items) begin
			sel = $urandom_range(99, 0);
			if (sel < 4 || shadow_x.size() > 48) begin
				add_cmd(MODE_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
				made++;
			end else if (sel < 7) begin
				// ignored by the block, not counted
				add_cmd(MODE_NONE, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
			end else if (sel < 30 || (shadow_x.size() == 0 && sel < 90)) begin
				if ($urandom_range(1, 0))
					add_cmd(MODE_APPEND, FIELD_W'($urandom), FIELD_W'($urandom),
						FIELD_W'($urandom));
				else
					add_cmd(MODE_APPEND, FIELD_W'($urandom_range(8191, 0) - 4096),
						FIELD_W'($urandom_range(8191, 0) - 4096), FIELD_W'($urandom));
				made++;
			end else if (sel < 85 && shadow_x.size() != 0) begin
				test_near($urandom_range(shadow_x.size() - 1, 0), reach);
				made++;
			end else begin
				// far-off point, or a test on an empty table
				add_cmd(MODE_TEST, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
				made++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : sequencer
		int idle_choice[3];
		int reach;
		logic [DATA_W-1:0] rad;
		idle_choice = '{0, 81, 22};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset radius (768^2): empty table, boundary, unused mode, heights.
		add_cmd(MODE_TEST, 24'sd0, 24'sd0, 24'sd5);           // empty table: nothing kept
		add_cmd(MODE_APPEND, 24'sd0, 24'sd0, 24'sd7);
		add_cmd(MODE_NONE, 24'sd0, 24'sd0, 24'sd0);           // must not append
		add_cmd(MODE_TEST, 24'sd768, 24'sd0, 24'sh7FFFFF);    // on the radius: not kept
		add_cmd(MODE_TEST, 24'sd767, 24'sd0, 24'sh800000);    // just inside
		add_cmd(MODE_TEST, 24'sd0, -24'sd768, 24'sd1);
		add_cmd(MODE_TEST, 24'sd0, -24'sd767, -24'sd1);
		add_cmd(MODE_TEST, -24'sd543, 24'sd543, 24'sd0);      // diagonal inside
		add_cmd(MODE_CLEAR, 24'sd0, 24'sd0, 24'sd0);
		add_cmd(MODE_TEST, 24'sd0, 24'sd0, 24'sd3);           // cleared: nothing kept
		add_cmd(MODE_APPEND, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
		add_cmd(MODE_APPEND, 24'sh7FFFFF, 24'sh800000, 24'sh800000);
		add_cmd(MODE_TEST, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
		add_cmd(MODE_TEST, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
		settle();

		// Largest radius, written with junk above bit 49: every test keeps its point.
		write_reg(RADIUS_ADDR, '1);
		add_cmd(MODE_TEST, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh123456);
		add_cmd(MODE_TEST, 24'sh800000, 24'sh800000, 24'sh654321);
		add_cmd(MODE_TEST, 24'sh000000, 24'shFFFFFF, 24'sh7FFFFF);
		settle();

		// Zero radius: even an exact hit is not below it.
		write_reg(RADIUS_ADDR, '0);
		add_cmd(MODE_TEST, 24'sh800000, 24'sh7FFFFF, 24'sh000001);
		settle();

		// Unmapped slot must leave the radius at zero.
		write_reg(UNMAPPED_ADDR, '1);
		add_cmd(MODE_TEST, 24'sh7FFFFF, 24'sh800000, 24'sh000002);
		settle();

		// Full table: two appends past capacity are dropped, misses walk all entries.
		write_reg(RADIUS_ADDR, DATA_W'(RAD_RESET));
		idle_pct = 22;
		add_cmd(MODE_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
		repeat (PATH_DEPTH + 2)
			add_cmd(MODE_APPEND, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
		test_near(0, 600);
		test_near(PATH_DEPTH - 1, 600);
		repeat (4) test_near($urandom_range(PATH_DEPTH - 1, 0), 900);
		repeat (6)
			add_cmd(MODE_TEST, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
		add_cmd(MODE_CLEAR, 24'sd0, 24'sd0, 24'sd0);
		settle();

		// Random phases, each setting a radius and sender idling.
		for (int ph = 0; ph < 6; ph++) begin
			idle_pct = idle_choice[ph % 3];
			case (ph)
				0: begin rad = DATA_W'(RAD_RESET); reach = 1200; end
				1: begin rad = {$urandom, $urandom}; reach = 2048; end
				2: begin rad = DATA_W'($urandom_range(4095, 1)); reach = 64; end
				3: begin rad = DATA_W'(1) << $urandom_range(26, 16); reach = 8192; end
				4: begin rad = DATA_W'(RAD_RESET); reach = 900; end
				default: begin rad = DATA_W'(1); reach = 2; end
			endcase
			write_reg(RADIUS_ADDR, rad);
			random_traffic(50, reach);
			settle();
		end

		if (kept_due.size() != 0) begin
			$display("%0t: %0d kept points expected but never seen", $time, kept_due.size());
			err_count++;
		end

		if (err_count == 0)
			$display("path_proximity_point_filter: match");
		else
			$display("path_proximity_point_filter: mismatch");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#40_000_000;
		$display("path_proximity_point_filter: mismatch");
		$finish;
	end

endmodule
